// ===== rtl/rgbup_pkg.sv =====
// Shared constants, types and the pixel blend function for the RGB565 line upscaler.
package rgbup_pkg;

    // Frame geometry
    localparam int IN_WORDS_PER_ROW = 80;
    localparam int ROW_GROUPS       = 48;
    localparam int ROWS_PER_GROUP   = 5;

    localparam int COL_W = (IN_WORDS_PER_ROW > 1) ? $clog2(IN_WORDS_PER_ROW) : 1;
    localparam int GRP_W = (ROW_GROUPS > 1) ? $clog2(ROW_GROUPS) : 1;

    // Field widths
    localparam int PIX_W  = 16;
    localparam int PAIR_W = 2 * PIX_W;
    localparam int ROW_W  = 8;
    localparam int OCOL_W = 8;

    localparam logic [PIX_W-1:0] BLEND_MASK = 16'hf7de;

    // Queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;

    // One classified input item, ready for output sequencing
    typedef struct packed {
        logic              pair_only;  // first row of a group: two results
        logic [PIX_W-1:0]  a_l;
        logic [PIX_W-1:0]  a_r;
        logic [PIX_W-1:0]  b_l;
        logic [PIX_W-1:0]  b_r;
        logic [ROW_W-1:0]  row_a;
        logic [ROW_W-1:0]  row_b;
        logic [OCOL_W-1:0] col;        // even output column of the left pixel
    } t_entry;

    // Average of two pixels per channel; equal pixels pass unchanged
    function automatic logic [PIX_W-1:0] blend16(input logic [PIX_W-1:0] p,
                                                 input logic [PIX_W-1:0] q);
        logic [PIX_W-1:0] hp;
        logic [PIX_W-1:0] hq;
        hp = (p & BLEND_MASK) >> 1;
        hq = (q & BLEND_MASK) >> 1;
        return (p == q) ? p : (hp + hq);
    endfunction

endpackage

// ===== rtl/rgbup_if.sv =====
// Valid/ready channel interfaces for the upscaler input and output items.
interface rgbup_in_if import rgbup_pkg::*;;
    logic              valid;
    logic              ready;
    logic [PAIR_W-1:0] in_pair;

    modport source (output valid, output in_pair, input ready);
    modport sink   (input valid, input in_pair, output ready);
endinterface

interface rgbup_out_if import rgbup_pkg::*;;
    logic              valid;
    logic              ready;
    logic [PIX_W-1:0]  out_pixel;
    logic [ROW_W-1:0]  out_row;
    logic [OCOL_W-1:0] out_col;
    logic              last_of_run;

    modport source (output valid, output out_pixel, output out_row, output out_col,
                    output last_of_run, input ready);
    modport sink   (input valid, input out_pixel, input out_row, input out_col,
                    input last_of_run, output ready);
endinterface

// ===== rtl/rgbup_front.sv =====
// Front end: raster counters, previous-row line store, blend and item classification.
module rgbup_front import rgbup_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    rgbup_in_if.sink       i_in,
    output logic           o_q_valid,
    input  logic           i_q_ready,
    output t_entry         o_q_entry
);

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_SECOND,
        PH_THIRD
    } t_phase;

    t_phase            r_phase;
    logic [COL_W-1:0]  r_col;
    logic [GRP_W-1:0]  r_grp;
    logic [ROW_W-1:0]  r_base;

    // Stage 1 item
    logic              r_s1_valid;
    logic              r_s1_first;
    logic [PAIR_W-1:0] r_s1_word;
    logic [ROW_W-1:0]  r_s1_row_a;
    logic [ROW_W-1:0]  r_s1_row_b;
    logic [OCOL_W-1:0] r_s1_col;

    // Line store and its registered read
    logic [PAIR_W-1:0] r_mem [IN_WORDS_PER_ROW];
    logic [PAIR_W-1:0] r_prev;

    logic              w_acc;
    logic [ROW_W-1:0]  n_row_a;

    assign i_in.ready = !r_s1_valid || i_q_ready;
    assign w_acc      = i_in.valid && i_in.ready;

    // Read old entry, then overwrite with the current word
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_prev       <= r_mem[r_col];
            r_mem[r_col] <= i_in.in_pair;
        end
    end

    // First output row caused by this item
    always_comb begin
        case (r_phase)
            PH_FIRST:  n_row_a = r_base;
            PH_SECOND: n_row_a = r_base + ROW_W'(1);
            PH_THIRD:  n_row_a = r_base + ROW_W'(3);
            default:   n_row_a = r_base;
        endcase
    end

    // Counters and stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_FIRST;
            r_col      <= '0;
            r_grp      <= '0;
            r_base     <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (w_acc) begin
                r_s1_valid <= 1'b1;
                r_s1_first <= (r_phase == PH_FIRST);
                r_s1_word  <= i_in.in_pair;
                r_s1_row_a <= n_row_a;
                r_s1_row_b <= n_row_a + ROW_W'(1);
                r_s1_col   <= OCOL_W'({r_col, 1'b0});
                if (r_col == COL_W'(IN_WORDS_PER_ROW - 1)) begin
                    r_col <= '0;
                    case (r_phase)
                        PH_FIRST:  r_phase <= PH_SECOND;
                        PH_SECOND: r_phase <= PH_THIRD;
                        default: begin
                            r_phase <= PH_FIRST;
                            if (r_grp == GRP_W'(ROW_GROUPS - 1)) begin
                                r_grp  <= '0;
                                r_base <= '0;
                            end else begin
                                r_grp  <= r_grp + GRP_W'(1);
                                r_base <= r_base + ROW_W'(ROWS_PER_GROUP);
                            end
                        end
                    endcase
                end else begin
                    r_col <= r_col + COL_W'(1);
                end
            end else if (i_q_ready) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // Queue item: blended pair first (copy on a first row), copied pair second
    always_comb begin
        o_q_entry.pair_only = r_s1_first;
        o_q_entry.row_a     = r_s1_row_a;
        o_q_entry.row_b     = r_s1_row_b;
        o_q_entry.col       = r_s1_col;
        o_q_entry.b_l       = r_s1_word[PIX_W-1:0];
        o_q_entry.b_r       = r_s1_word[PAIR_W-1:PIX_W];
        if (r_s1_first) begin
            o_q_entry.a_l = r_s1_word[PIX_W-1:0];
            o_q_entry.a_r = r_s1_word[PAIR_W-1:PIX_W];
        end else begin
            o_q_entry.a_l = blend16(r_prev[PIX_W-1:0], r_s1_word[PIX_W-1:0]);
            o_q_entry.a_r = blend16(r_prev[PAIR_W-1:PIX_W], r_s1_word[PAIR_W-1:PIX_W]);
        end
    end

    assign o_q_valid = r_s1_valid;

endmodule

// ===== rtl/rgbup_fifo.sv =====
// Short register queue that decouples the front end from the output sequencer.
module rgbup_fifo import rgbup_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push_valid,
    output logic   o_push_ready,
    input  t_entry i_push_entry,
    output logic   o_pop_valid,
    input  logic   i_pop_ready,
    output t_entry o_pop_entry
);

    t_entry             r_buf [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr;
    logic [Q_PTR_W-1:0] r_rd;
    logic [Q_PTR_W:0]   r_cnt;

    logic w_push;
    logic w_pop;

    assign o_push_ready = (r_cnt != (Q_PTR_W+1)'(Q_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_entry  = r_buf[r_rd];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    // Storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wr] <= i_push_entry;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + Q_PTR_W'(1);
            end
            if (w_pop) begin
                r_rd <= r_rd + Q_PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + (Q_PTR_W+1)'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - (Q_PTR_W+1)'(1);
            end
        end
    end

endmodule

// ===== rtl/rgbup_back.sv =====
// Back end: steps through the two or four results of each queued item into an output register.
module rgbup_back import rgbup_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    output logic      o_q_pop,
    input  t_entry    i_q_entry,
    rgbup_out_if.source o_out
);

    logic [1:0]        r_idx;
    logic              r_out_valid;
    logic [PIX_W-1:0]  r_pixel;
    logic [ROW_W-1:0]  r_row;
    logic [OCOL_W-1:0] r_col;
    logic              r_last;

    logic              w_load;
    logic              w_take;
    logic [PIX_W-1:0]  n_pixel;
    logic [ROW_W-1:0]  n_row;
    logic [OCOL_W-1:0] n_col;
    logic              n_last;

    assign w_load  = !r_out_valid || o_out.ready;
    assign w_take  = w_load && i_q_valid;
    assign o_q_pop = w_take && n_last;

    // Select the result at the current index
    always_comb begin
        case (r_idx)
            2'd0: begin
                n_pixel = i_q_entry.a_l;
                n_row   = i_q_entry.row_a;
                n_col   = i_q_entry.col;
                n_last  = 1'b0;
            end
            2'd1: begin
                n_pixel = i_q_entry.a_r;
                n_row   = i_q_entry.row_a;
                n_col   = {i_q_entry.col[OCOL_W-1:1], 1'b1};
                n_last  = i_q_entry.pair_only;
            end
            2'd2: begin
                n_pixel = i_q_entry.b_l;
                n_row   = i_q_entry.row_b;
                n_col   = i_q_entry.col;
                n_last  = 1'b0;
            end
            default: begin
                n_pixel = i_q_entry.b_r;
                n_row   = i_q_entry.row_b;
                n_col   = {i_q_entry.col[OCOL_W-1:1], 1'b1};
                n_last  = 1'b1;
            end
        endcase
    end

    // Index and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= i_q_valid;
            if (i_q_valid) begin
                r_idx   <= n_last ? 2'd0 : r_idx + 2'd1;
                r_pixel <= n_pixel;
                r_row   <= n_row;
                r_col   <= n_col;
                r_last  <= n_last;
            end
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.out_pixel   = r_pixel;
    assign o_out.out_row     = r_row;
    assign o_out.out_col     = r_col;
    assign o_out.last_of_run = r_last;

endmodule

// ===== rtl/rgb565_upscale_2x_by_5_3.sv =====
// Top level of the RGB565 3-to-5 line upscaler.
// Input channel i_in: one item per 32-bit word holding two RGB565 pixels,
// left pixel in bits 15..0, in raster order, 80 words per row, 144 rows.
// Output channel o_out: one item per output pixel, carrying that pixel,
// its output row and column, and a flag on the final item caused by
// each input word.
// A word of the first row of a group gives 2 output items; words of the
// second and third rows give 4 (blended row first, then the copied row).
// The output register sends one item per cycle while the receiver holds
// ready high, so the result port is the limit. The front end takes a
// word every cycle until its 4-entry queue fills, so input and output
// stall independently.
// The first output item of a word passes through the stage 1 register,
// the queue and the output register when nothing stalls.
// Reset (synchronous, active low) clears the row/column counters, the
// queue and the output register; the line store is not cleared, as the
// first row of a group refills it before use. Counters wrap at frame end.
// When the receiver holds ready low the output item is held, the queue
// fills and then the input ready drops.
module rgb565_upscale_2x_by_5_3 import rgbup_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rgbup_in_if.sink    i_in,
    rgbup_out_if.source o_out
);

    logic   w_f_valid;
    logic   w_f_ready;
    t_entry w_f_entry;
    logic   w_q_valid;
    logic   w_q_pop;
    t_entry w_q_entry;

    // Counters, line store and blend
    rgbup_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_q_valid (w_f_valid),
        .i_q_ready (w_f_ready),
        .o_q_entry (w_f_entry)
    );

    // Decoupling queue
    rgbup_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_f_valid),
        .o_push_ready (w_f_ready),
        .i_push_entry (w_f_entry),
        .o_pop_valid  (w_q_valid),
        .i_pop_ready  (w_q_pop),
        .o_pop_entry  (w_q_entry)
    );

    // Output sequencing
    rgbup_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .o_q_pop   (w_q_pop),
        .i_q_entry (w_q_entry),
        .o_out     (o_out)
    );

`ifndef SYNTH
    // Reset empties both the queue and the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid && !w_q_valid)
        else $error("output or queue not empty after reset");

    // An item stays queued until its final result is loaded
    a_item_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.ready && !o_out.last_of_run |-> w_q_valid)
        else $error("queued item dropped before its final result");

    // The final result of an item is always the right pixel
    a_last_right: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.last_of_run |-> o_out.out_col[0])
        else $error("final result not on an odd column");
`endif

endmodule
